// ===== src/conv3x3_image_filter_unit_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef CONV3X3_IMAGE_FILTER_UNIT_MACROS_SVH
`define CONV3X3_IMAGE_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define C3F_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define C3F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define C3F_ASSERT(label, clk, rst_n, prop, msg)

`define C3F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/c3f_pkg.sv =====
package c3f_pkg;

  localparam int PixW     = 24;
  localparam int ChanW    = 8;
  localparam int NumChan  = 3;
  localparam int Taps     = 9;
  localparam int ModeW    = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 3;

  // Weighted sums stay within -2040..4080.
  localparam int SumW     = 14;
  localparam int PosW     = 12;
  localparam int FracBits = 16;
  localparam int RecipW   = FracBits + 1;
  localparam int ProdW    = PosW + RecipW;
  localparam int QuotW    = ProdW - FracBits;

  localparam int RecipOne     = 1 << FracBits;
  localparam int RecipThree   = 21846;
  localparam int RecipNine    = 7282;
  localparam int RecipSixteen = RecipOne / 16;

  localparam int Depth = 8;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = PtrW + 1;

  typedef enum logic [ModeW-1:0] {
    FM_IDENTITY = 3'd0,
    FM_SMOOTH   = 3'd1,
    FM_GAUSS    = 3'd2,
    FM_SHARPEN  = 3'd3,
    FM_EMBOSS   = 3'd4,
    FM_MEAN_REM = 3'd5
  } filt_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FILTER_MODE = 1'b0,
    REG_COLOR_MODE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              sum_en;
    logic              div_en;
    logic [ModeW-1:0]  mode;
  } lane_ctl_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            row_end;
  } res_t;

  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      res;
  } push_t;

  function automatic logic [RecipW-1:0] kern_recip(input logic [ModeW-1:0] mode);
    case (filt_mode_e'(mode))
      FM_SMOOTH:  return RecipW'(RecipNine);
      FM_GAUSS:   return RecipW'(RecipSixteen);
      FM_SHARPEN: return RecipW'(RecipThree);
      default:    return RecipW'(RecipOne);
    endcase
  endfunction

  function automatic logic [PixW-1:0] pass_pix(input logic [PixW-1:0] p, input logic color);
    return color ? p : PixW'(p[ChanW-1:0]);
  endfunction

endpackage

// ===== src/c3f_if.sv =====
interface c3f_in_if;
  import c3f_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] top_pixel;
  logic [PixW-1:0] mid_pixel;
  logic [PixW-1:0] bot_pixel;
  logic            row_border;
  logic            col_last;

  modport source (
    output valid, top_pixel, mid_pixel, bot_pixel, row_border, col_last,
    input  ready
  );
  modport sink (
    input  valid, top_pixel, mid_pixel, bot_pixel, row_border, col_last,
    output ready
  );
endinterface

interface c3f_out_if;
  import c3f_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_pixel;
  logic            row_end;

  modport source (
    output valid, out_pixel, row_end,
    input  ready
  );
  modport sink (
    input  valid, out_pixel, row_end,
    output ready
  );
endinterface

// ===== src/c3f_lane.sv =====
module c3f_lane (
  input  logic                                      clk_i,
  input  c3f_pkg::lane_ctl_t                        ctl_i,
  input  logic [c3f_pkg::Taps-1:0][c3f_pkg::ChanW-1:0] px_i,
  output logic [c3f_pkg::ChanW-1:0]                 chan_o
);
  import c3f_pkg::*;

  logic signed [SumW-1:0]  ext [Taps];
  logic signed [SumW-1:0]  all_sum;
  logic signed [SumW-1:0]  edges;
  logic signed [SumW-1:0]  corners;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic [PosW-1:0]         pos;
  logic [ProdW-1:0]        prod;
  logic [QuotW-1:0]        quot;
  logic [ChanW-1:0]        chan_d, chan_q;

  // px_i index is row * 3 + column, column oldest to newest
  always_comb begin
    for (int k = 0; k < Taps; k++) begin
      ext[k] = $signed({{(SumW - ChanW){1'b0}}, px_i[k]});
    end
    edges   = ext[1] + ext[3] + ext[5] + ext[7];
    corners = ext[0] + ext[2] + ext[6] + ext[8];
    all_sum = edges + corners + ext[4];
    case (filt_mode_e'(ctl_i.mode))
      FM_SMOOTH:   sum_d = all_sum;
      FM_GAUSS:    sum_d = corners + (edges <<< 1) + (ext[4] <<< 2);
      FM_SHARPEN:  sum_d = (ext[4] <<< 3) + (ext[4] <<< 1) + ext[4] - (edges <<< 1);
      FM_EMBOSS:   sum_d = ext[1] - ext[7];
      FM_MEAN_REM: sum_d = (ext[4] <<< 3) + (ext[4] <<< 1) - all_sum;
      default:     sum_d = ext[4];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  // Divide by reciprocal multiply; clamp non-positive sums to zero first
  always_comb begin
    pos  = (sum_q > 0) ? sum_q[PosW-1:0] : '0;
    prod = ProdW'(pos) * ProdW'(kern_recip(ctl_i.mode));
    quot = prod[ProdW-1:FracBits];
    chan_d = (quot > QuotW'({ChanW{1'b1}})) ? {ChanW{1'b1}} : quot[ChanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_en) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

// ===== src/c3f_outq.sv =====
module c3f_outq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  c3f_pkg::push_t           push_i,
  c3f_out_if.source                out_chan,
  output logic [c3f_pkg::CntW-1:0] cnt_o
);
  import c3f_pkg::*;

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_i.n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.res[1];
    end
  end

  assign out_chan.valid     = (cnt_q != '0);
  assign out_chan.out_pixel = mem_q[rd_ptr_q].pixel;
  assign out_chan.row_end   = mem_q[rd_ptr_q].row_end;
  assign cnt_o              = cnt_q;

endmodule

// ===== src/conv3x3_image_filter_unit.sv =====
// Channel    Direction  Moves
// in_chan    sink       one pixel column: top, mid, bot, row_border, col_last
// out_chan   source     one centre pixel with row_end
// cfg        write      filter_mode (index 0), color_mode (index 1)
//
// One column request is taken per cycle while ready is high; its results pass the
// lane sum stage and divide stage and enter an eight-entry result queue.
// A last column gives two results, or one if it is also the first of its row,
// so a row of N columns gives N results for N requests. ready drops while queued plus
// in-flight results exceed six.
// Reset clears the window, column count, pipeline and queue.
`include "conv3x3_image_filter_unit_macros.svh"

module conv3x3_image_filter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  c3f_in_if.sink                       in_chan,
  c3f_out_if.source                    out_chan,
  input  logic                         cfg_we_i,
  input  logic [c3f_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [c3f_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import c3f_pkg::*;

  localparam int          OccW     = CntW + 1;
  localparam logic [1:0]  ColsFull = 2'd2;

  typedef struct packed {
    logic            valid;
    logic            emit_prev;
    logic            prev_pass;
    logic            emit_last;
    logic [PixW-1:0] prev_pix;
    logic [PixW-1:0] last_pix;
  } stage_t;

  logic [ModeW-1:0] filter_mode_q;
  logic             color_mode_q;
  logic [PixW-1:0]  win_q [6];
  logic [1:0]       cols_seen_q;
  logic             prev_border_q;
  stage_t           s1_q, s1_d, s2_q;
  logic             in_fire;
  logic [PixW-1:0]  cur [3];
  lane_ctl_t        lane_ctl;
  logic [NumChan-1:0][Taps-1:0][ChanW-1:0] lane_px;
  logic [NumChan-1:0][ChanW-1:0]           lane_chan;
  logic [PixW-1:0]  filt_pix;
  logic [PixW-1:0]  prev_res;
  push_t            push;
  logic [CntW-1:0]  q_cnt;
  logic [OccW-1:0]  inflight;
  logic [OccW-1:0]  occupancy;

  assign cur[0] = in_chan.top_pixel;
  assign cur[1] = in_chan.mid_pixel;
  assign cur[2] = in_chan.bot_pixel;

  assign inflight = OccW'(s1_q.valid & s1_q.emit_prev) + OccW'(s1_q.valid & s1_q.emit_last)
                  + OccW'(s2_q.valid & s2_q.emit_prev) + OccW'(s2_q.valid & s2_q.emit_last);
  assign occupancy     = OccW'(q_cnt) + inflight;
  assign in_chan.ready = (occupancy <= OccW'(Depth - 2));
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= '0;
      color_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FILTER_MODE: filter_mode_q <= cfg_wdata_i[ModeW-1:0];
        REG_COLOR_MODE:  color_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Column window and row position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 6; r++) begin
        win_q[r] <= '0;
      end
      cols_seen_q   <= '0;
      prev_border_q <= 1'b0;
    end else if (in_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_q[3 + r] <= win_q[r];
        win_q[r]     <= cur[r];
      end
      prev_border_q <= in_chan.row_border;
      if (in_chan.col_last) begin
        cols_seen_q <= '0;
      end else if (cols_seen_q != ColsFull) begin
        cols_seen_q <= cols_seen_q + 2'd1;
      end
    end
  end

  always_comb begin
    s1_d.valid     = in_fire;
    s1_d.emit_prev = (cols_seen_q != '0);
    s1_d.prev_pass = (cols_seen_q == 2'd1) || prev_border_q;
    s1_d.emit_last = in_chan.col_last;
    s1_d.prev_pix  = pass_pix(win_q[1], color_mode_q);
    s1_d.last_pix  = pass_pix(cur[1], color_mode_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  assign lane_ctl.sum_en = in_fire;
  assign lane_ctl.div_en = s1_q.valid;
  assign lane_ctl.mode   = filter_mode_q;

  for (genvar k = 0; k < NumChan; k++) begin : g_lane
    always_comb begin
      for (int r = 0; r < 3; r++) begin
        lane_px[k][r * 3 + 0] = win_q[3 + r][k * ChanW +: ChanW];
        lane_px[k][r * 3 + 1] = win_q[r][k * ChanW +: ChanW];
        lane_px[k][r * 3 + 2] = cur[r][k * ChanW +: ChanW];
      end
    end

    c3f_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .px_i   (lane_px[k]),
      .chan_o (lane_chan[k])
    );
  end

  // Merge lanes and order the two possible results of a column
  always_comb begin
    filt_pix = color_mode_q ? PixW'(lane_chan) : PixW'(lane_chan[0]);
    prev_res = s2_q.prev_pass ? s2_q.prev_pix : filt_pix;
    push.n   = 2'd0;
    push.res[0].pixel   = prev_res;
    push.res[0].row_end = 1'b0;
    push.res[1].pixel   = s2_q.last_pix;
    push.res[1].row_end = 1'b1;
    if (s2_q.valid) begin
      if (s2_q.emit_prev && s2_q.emit_last) begin
        push.n = 2'd2;
      end else if (s2_q.emit_prev) begin
        push.n = 2'd1;
      end else if (s2_q.emit_last) begin
        push.n = 2'd1;
        push.res[0] = push.res[1];
      end
    end
  end

  c3f_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .out_chan (out_chan),
    .cnt_o    (q_cnt)
  );

  `C3F_ASSERT(a_queue_room, clk_i, rst_ni, occupancy <= OccW'(Depth), "result queue overbooked")
  `C3F_ASSERT_NEXT(a_row_restart, clk_i, rst_ni, in_fire && in_chan.col_last, cols_seen_q == '0, "column count not cleared at row end")
  `C3F_ASSERT_NEXT(a_pipe_advance, clk_i, rst_ni, s1_q.valid, s2_q.valid, "lane pipeline lost a request")

endmodule

// ===== dv/conv3x3_image_filter_checker.sv =====
module conv3x3_image_filter_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  c3f_in_if                            in_chan,
  c3f_out_if                           out_chan,
  input  logic                         cfg_we_i,
  input  logic [c3f_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [c3f_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                           errors_o,
  output int                           pending_o
);
  import c3f_pkg::*;

  res_t             pixels_due_q[$];
  logic [PixW-1:0]  window_q[6];
  logic [1:0]       cols_seen_q;
  logic             prev_border_q;
  logic [ModeW-1:0] filt_mode_q;
  logic             rgb_q;
  int               err_cnt;

  function automatic logic [PixW-1:0] keep_pixel(input logic [PixW-1:0] p);
    return rgb_q ? p : {{(PixW-ChanW){1'b0}}, p[ChanW-1:0]};
  endfunction

  // g holds one lane of the window, row-major, oldest column first
  function automatic logic [ChanW-1:0] weigh_lane(input logic [Taps-1:0][ChanW-1:0] g,
                                                  input logic [ModeW-1:0] mode);
    int centre;
    int edges;
    int corners;
    int acc;
    int denom;
    centre  = g[4];
    edges   = g[1] + g[3] + g[5] + g[7];
    corners = g[0] + g[2] + g[6] + g[8];
    denom   = 1;
    case (filt_mode_e'(mode))
      FM_SMOOTH: begin
        acc   = centre + edges + corners;
        denom = 9;
      end
      FM_GAUSS: begin
        acc   = 4 * centre + 2 * edges + corners;
        denom = 16;
      end
      FM_SHARPEN: begin
        acc   = 11 * centre - 2 * edges;
        denom = 3;
      end
      FM_EMBOSS:   acc = int'(g[1]) - int'(g[7]);
      FM_MEAN_REM: acc = 9 * centre - edges - corners;
      default:     acc = centre;
    endcase
    if (acc <= 0) return '0;
    acc = acc / denom;
    if (acc > 255) acc = 255;
    return acc[ChanW-1:0];
  endfunction

  task automatic take_column(input logic [2:0][PixW-1:0] cur, input logic brd, input logic lst);
    logic [PixW-1:0]            pix;
    logic [Taps-1:0][ChanW-1:0] lane;
    if (cols_seen_q != 2'd0) begin
      if (cols_seen_q == 2'd1 || prev_border_q) begin
        pix = keep_pixel(window_q[1]);
      end else begin
        pix = '0;
        for (int ch = 0; ch < NumChan; ch++) begin
          for (int r = 0; r < 3; r++) begin
            lane[r*3]   = window_q[3+r][ch*ChanW +: ChanW];
            lane[r*3+1] = window_q[r][ch*ChanW +: ChanW];
            lane[r*3+2] = cur[r][ch*ChanW +: ChanW];
          end
          if (ch == 0 || rgb_q) pix[ch*ChanW +: ChanW] = weigh_lane(lane, filt_mode_q);
        end
      end
      pixels_due_q.push_back(res_t'{pixel: pix, row_end: 1'b0});
    end
    if (lst) pixels_due_q.push_back(res_t'{pixel: keep_pixel(cur[1]), row_end: 1'b1});
    for (int r = 0; r < 3; r++) begin
      window_q[3+r] = window_q[r];
      window_q[r]   = cur[r];
    end
    prev_border_q = brd;
    if (lst) cols_seen_q = 2'd0;
    else if (cols_seen_q < 2'd2) cols_seen_q = cols_seen_q + 2'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pixels_due_q.delete();
      for (int i = 0; i < 6; i++) window_q[i] = '0;
      cols_seen_q   = '0;
      prev_border_q = 1'b0;
      filt_mode_q   = FM_IDENTITY;
      rgb_q         = 1'b0;
      err_cnt       = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        take_column({in_chan.bot_pixel, in_chan.mid_pixel, in_chan.top_pixel},
                    in_chan.row_border, in_chan.col_last);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pixels_due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected pixel %h row_end %b", $time,
                   out_chan.out_pixel, out_chan.row_end);
        end else begin
          want = pixels_due_q.pop_front();
          if (out_chan.out_pixel !== want.pixel) begin
            err_cnt++;
            $display("%0t: out_pixel expected %h actual %h", $time, want.pixel,
                     out_chan.out_pixel);
          end
          if (out_chan.row_end !== want.row_end) begin
            err_cnt++;
            $display("%0t: row_end expected %b actual %b", $time, want.row_end,
                     out_chan.row_end);
          end
        end
      end
      // user keeps block idle while these are written; the block does not enforce it
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_FILTER_MODE: filt_mode_q = cfg_wdata_i[ModeW-1:0];
          REG_COLOR_MODE:  rgb_q       = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    errors_o  <= err_cnt;
    pending_o <= pixels_due_q.size();
  end

endmodule

// ===== dv/tb_conv3x3_image_filter_unit.sv =====
module tb_conv3x3_image_filter_unit;
  import c3f_pkg::*;

  localparam int               PhaseItems = 44;
  localparam int               HoldCycles = 200;
  localparam int               IdleCycles = 8;
  localparam int               CycleLimit = 300000;
  localparam logic [ModeW-1:0] FmUnusedLo = 3'd6;
  localparam logic [ModeW-1:0] FmUnusedHi = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                calm;
  int                  holds_asked;
  int                  sent;
  int                  cycles;
  int                  errors;
  int                  pending;

  c3f_in_if  in_chan ();
  c3f_out_if out_chan ();

  conv3x3_image_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  conv3x3_image_filter_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sink side: random back-pressure, with a long hold-off whenever one is asked for
  initial begin : sink_proc
    int holds_done;
    holds_done     = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_chan.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        out_chan.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_chan.ready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  function automatic logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] p;
    for (int ch = 0; ch < NumChan; ch++) begin
      case ($urandom_range(0, 3))
        0:       p[ch*ChanW +: ChanW] = 8'h00;
        1:       p[ch*ChanW +: ChanW] = 8'hFF;
        default: p[ch*ChanW +: ChanW] = ChanW'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  task automatic send_column(input logic [PixW-1:0] top, input logic [PixW-1:0] mid,
                             input logic [PixW-1:0] bot, input logic brd, input logic lst);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid      <= 1'b1;
    in_chan.top_pixel  <= top;
    in_chan.mid_pixel  <= mid;
    in_chan.bot_pixel  <= bot;
    in_chan.row_border <= brd;
    in_chan.col_last   <= lst;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    sent++;
  endtask

  // mostly whole rows with one border flag; now and then scramble the flag per column
  task automatic send_random_row();
    int   len;
    logic brd;
    logic noisy;
    case ($urandom_range(0, 19))
      0:             len = $urandom_range(17, 40);
      1, 2, 3, 4, 5: len = $urandom_range(7, 16);
      default:       len = $urandom_range(1, 6);
    endcase
    brd   = ($urandom_range(0, 4) == 0);
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      send_column(rand_pixel(), rand_pixel(), rand_pixel(),
                  noisy ? 1'($urandom_range(0, 1)) : brd, i == len - 1);
    end
  endtask

  // drop valid and wait until every expected pixel is out and the pipe is empty
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_filter_regs(input logic [ModeW-1:0] mode, input logic rgb);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FILTER_MODE;
    cfg_wdata <= CfgDataW'(mode);
    @(posedge clk_i);
    cfg_idx   <= REG_COLOR_MODE;
    cfg_wdata <= CfgDataW'(rgb);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [ModeW-1:0] mode, input logic rgb,
                           input logic quiet, input logic hold);
    int start;
    settle();
    write_filter_regs(mode, rgb);
    if (quiet) calm <= 1'b1;
    if (hold) holds_asked <= holds_asked + 1;
    start = sent;
    while (sent - start < PhaseItems) send_random_row();
    calm <= 1'b0;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_FILTER_MODE;
    cfg_wdata          = '0;
    calm               = 1'b0;
    holds_asked        = 0;
    sent               = 0;
    cycles             = 0;
    in_chan.valid      = 1'b0;
    in_chan.top_pixel  = '0;
    in_chan.mid_pixel  = '0;
    in_chan.bot_pixel  = '0;
    in_chan.row_border = 1'b0;
    in_chan.col_last   = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: identity, greyscale; upper bits must be dropped
    send_column(24'hFFFFFF, 24'hABCDEF, 24'h123456, 1'b0, 1'b1);
    send_column(24'h010203, 24'hFFFF80, 24'h7F7F7F, 1'b0, 1'b0);
    send_column(24'h000000, 24'hFFFFFF, 24'h000000, 1'b0, 1'b1);
    send_column(24'h111111, 24'h222222, 24'h333333, 1'b1, 1'b0);
    send_column(24'h444444, 24'h555555, 24'h666666, 1'b1, 1'b0);
    send_column(24'h777777, 24'h888888, 24'h999999, 1'b1, 1'b1);
    send_column(24'hFFFF00, 24'hA5A5FF, 24'h5A5A00, 1'b0, 1'b0);
    send_column(24'h00FFFF, 24'hFF0001, 24'hFFFFFE, 1'b0, 1'b0);
    send_column(24'h800080, 24'h7FFF7F, 24'hFF00FF, 1'b0, 1'b1);

    // saturate high, then drive the sum negative
    settle();
    write_filter_regs(FM_MEAN_REM, 1'b1);
    send_column(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0);
    send_column(24'h000000, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0);
    send_column(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1);
    send_column(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0);
    send_column(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0);
    send_column(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1);

    run_phase(FM_IDENTITY, 1'b1, 1'b0, 1'b0);
    run_phase(FM_SMOOTH,   1'b0, 1'b0, 1'b1);
    run_phase(FM_SMOOTH,   1'b1, 1'b0, 1'b0);
    run_phase(FM_GAUSS,    1'b0, 1'b1, 1'b0);
    run_phase(FM_GAUSS,    1'b1, 1'b0, 1'b0);
    run_phase(FM_SHARPEN,  1'b0, 1'b0, 1'b0);
    run_phase(FM_SHARPEN,  1'b1, 1'b0, 1'b1);
    run_phase(FM_EMBOSS,   1'b0, 1'b0, 1'b0);
    run_phase(FM_EMBOSS,   1'b1, 1'b0, 1'b0);
    run_phase(FM_MEAN_REM, 1'b0, 1'b0, 1'b0);
    run_phase(FM_MEAN_REM, 1'b1, 1'b0, 1'b0);
    run_phase(FmUnusedLo,  1'b1, 1'b0, 1'b0);
    run_phase(FmUnusedHi,  1'b0, 1'b0, 1'b1);

    settle();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
